// ----- design/lrbt_pkg.sv -----
// Shared types and sizes for the latest-record-before-time lookup.
// Used by the record cell and the top level; no dependencies.
`default_nettype none

package lrbt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int PRN_SLOTS   = 64;

   localparam int PRN_W   = 6;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 9;
   localparam int SLOT_W  = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

   localparam logic CSR_MAX_AGE = 1'b0;
   localparam logic CSR_MAX_PRN = 1'b1;

   typedef struct packed {
      logic [PRN_W-1:0]  prn;
      logic [TIME_W-1:0] time_sec;
   } rec_type;

   typedef struct packed {
      logic shift;
      logic rotate;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- design/lrbt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lrbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/lrbt_cell.sv -----
// One record cell of the chain: shifts toward the old end on append and
// rotates toward cell zero during a scan. Depends on lrbt_pkg.
`default_nettype none

module lrbt_cell import lrbt_pkg::*; (
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire rec_type      left_in,
   input  wire rec_type      right_in,
   output rec_type           rec_out
);

   rec_type rec_ff;
   rec_type rec_in;

   always_comb begin
      rec_in = rec_ff;
      if (ctl.shift) begin
         rec_in = left_in;
      end else if (ctl.rotate) begin
         rec_in = right_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec_out = rec_ff;

endmodule

`default_nettype wire

// ----- design/latest_record_before_time_lookup.sv -----
// Top level of the latest-record-before-time lookup: sequencer, record
// chain and per-satellite counters. Depends on lrbt_pkg, lrbt_cell, lrbt_ram.
//
//   channel  direction  word contents
//   req_     in         tuser: action; tdata: prn, time_sec
//   rsp_     out        tdata: found, fresh, slot_index, held_count, table_full, prn_invalid
//   csr_     in         index 0 max_age_sec, index 1 max_prn
//
// An append or a rejected query passes the read, apply and done states from accept
// to result; any other query also passes the scan state, one full rotation of the
// record chain past cell zero, one record per cycle. One word is worked at a time.
// Reset clears the record count and the counter valid bits.
// A waiting result holds the sequencer before the next result is loaded.
`default_nettype none

module latest_record_before_time_lookup import lrbt_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // prn[5:0], time_sec[37:6], zero[39:38]
   input  wire logic [0:0]  req_tuser,   // action[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // found, fresh, slot_index, held_count,
                                         // table_full, prn_invalid, zero[23:21]
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int TOT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int PRN_AW = $clog2(PRN_SLOTS);

   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD    = 3'd1;
   localparam logic [2:0] ST_APPLY = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [31:0]       max_age_ff;
   logic [PRN_W-1:0]  max_prn_ff;

   logic              action_ff;
   logic [PRN_W-1:0]  prn_ff;
   logic [TIME_W-1:0] time_ff;

   logic              found_ff, found_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic              full_ff, full_in;
   logic              inval_ff, inval_in;
   logic [TIME_W-1:0] hit_time_ff, hit_time_in;

   logic              rsp_valid_ff;
   logic [20:0]       rsp_data_ff;

   logic              cnt_vld_ff [PRN_SLOTS];
   logic              cnt_vld_rd_ff;
   logic [PRN_AW-1:0] cnt_addr;
   logic [COUNT_W-1:0] cnt_q;
   logic [COUNT_W-1:0] cnt_old;
   logic [COUNT_W-1:0] cnt_new;
   logic              cnt_we;
   logic              has_ctr;

   cell_ctl_type      ctl;
   rec_type           new_rec;
   rec_type           cell_q [TABLE_DEPTH];

   logic              scan_hit;
   logic              rsp_free;
   logic              fresh;

   // record chain, newest record in cell zero
   assign new_rec.prn      = prn_ff;
   assign new_rec.time_sec = time_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      rec_type left_rec;
      rec_type right_rec;
      if (i == 0) begin : g_head
         assign left_rec = new_rec;
      end else begin : g_body
         assign left_rec = cell_q[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign right_rec = cell_q[0];
      end else begin : g_mid
         assign right_rec = cell_q[i+1];
      end
      lrbt_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .left_in  (left_rec),
         .right_in (right_rec),
         .rec_out  (cell_q[i])
      );
   end

   // per-satellite counters
   assign cnt_addr = PRN_AW'(prn_ff);
   assign has_ctr  = (32'(prn_ff) < PRN_SLOTS);
   assign cnt_old  = (has_ctr && cnt_vld_rd_ff) ? cnt_q : '0;
   assign cnt_new  = (cnt_old < COUNT_MAX) ? cnt_old + COUNT_W'(1) : cnt_old;
   assign cnt_we   = (state_ff == ST_APPLY) && !action_ff &&
                     (total_ff < TOT_W'(TABLE_DEPTH)) && has_ctr;

   lrbt_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (PRN_SLOTS)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_addr),
      .wdata (cnt_new),
      .raddr (cnt_addr),
      .rdata (cnt_q)
   );

   always_ff @(posedge clock) begin
      cnt_vld_rd_ff <= cnt_vld_ff[cnt_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PRN_SLOTS; i++) begin
            cnt_vld_ff[i] <= 1'b0;
         end
      end else if (cnt_we) begin
         cnt_vld_ff[cnt_addr] <= 1'b1;
      end
   end

   // sequencer
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign scan_hit   = !found_ff && (TOT_W'(step_ff) < total_ff) &&
                       (cell_q[0].prn == prn_ff) && (cell_q[0].time_sec <= time_ff);
   assign fresh      = found_ff && ((time_ff - hit_time_ff) <= max_age_ff);

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      step_in     = step_ff;
      found_in    = found_ff;
      slot_in     = slot_ff;
      cnt_in      = cnt_ff;
      full_in     = full_ff;
      inval_in    = inval_ff;
      hit_time_in = hit_time_ff;
      ctl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            found_in = 1'b0;
            slot_in  = '0;
            cnt_in   = '0;
            full_in  = 1'b0;
            inval_in = 1'b0;
            step_in  = '0;
            state_in = ST_DONE;
            if (!action_ff) begin
               if (total_ff >= TOT_W'(TABLE_DEPTH)) begin
                  full_in = 1'b1;
                  cnt_in  = cnt_old;
               end else begin
                  ctl.shift = 1'b1;
                  slot_in   = SLOT_W'(total_ff);
                  total_in  = total_ff + TOT_W'(1);
                  cnt_in    = has_ctr ? cnt_new : '0;
               end
            end else if (prn_ff == '0 || prn_ff > max_prn_ff) begin
               inval_in = 1'b1;
            end else begin
               cnt_in   = cnt_old;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl.rotate = 1'b1;
            if (scan_hit) begin
               found_in    = 1'b1;
               slot_in     = SLOT_W'(total_ff - TOT_W'(step_ff) - TOT_W'(1));
               hit_time_in = cell_q[0].time_sec;
            end
            step_in = step_ff + IDX_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff    <= found_in;
      slot_ff     <= slot_in;
      cnt_ff      <= cnt_in;
      full_ff     <= full_in;
      inval_ff    <= inval_in;
      hit_time_ff <= hit_time_in;
      if (req_tvalid && req_tready) begin
         action_ff <= req_tuser[0];
         prn_ff    <= req_tdata[5:0];
         time_ff   <= req_tdata[37:6];
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= 32'd7200;
         max_prn_ff <= 6'd36;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_AGE: max_age_ff <= csr_wdata;
            CSR_MAX_PRN: max_prn_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_data_ff <= {inval_ff, full_ff, cnt_ff, slot_ff, fresh, found_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   a_fresh_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("fresh result without a match");

   a_found_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[19] && !rsp_tdata[20])
      else $error("matched result carries a full or invalid flag");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOT_W'(TABLE_DEPTH))
      else $error("record count beyond table depth");

   a_scan_advance: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && step_ff != LAST_STEP |=>
         state_ff == ST_SCAN && step_ff == $past(step_ff) + IDX_W'(1))
      else $error("scan step did not advance");

endmodule

`default_nettype wire
